>>> hdl/gld_pkg.sv
// -----------------------------------------------------------------------------
// gld_pkg: shared types and constants for the GIF LZW decoder
// Holds action and status codes, register indices and the controller/datapath command and status structs.
// -----------------------------------------------------------------------------
package gld_pkg;

  localparam int unsigned CODE_W  = 12;
  localparam int unsigned COUNT_W = 27;
  localparam int unsigned MAX_WIDTH = 12;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_PULL  = 2'd2,
    ACT_END   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_PIXEL     = 3'd0,
    ST_NEED_BYTE = 3'd1,
    ST_TAKEN     = 3'd2,
    ST_DONE_OK   = 3'd3,
    ST_DONE_NONE = 3'd4,
    ST_REJECTED  = 3'd5
  } status_t;

  localparam logic [3:0] REG_MIN_CODE_SIZE = 4'd0;
  localparam logic [3:0] REG_PIXEL_LIMIT   = 4'd1;

  // controller -> datapath
  typedef struct packed {
    logic start;       // image start
    logic take_byte;   // process a data byte
    logic end_data;    // end of data action
    logic read_code;   // extract next code, classify it
    logic walk_start;  // begin string expansion
    logic walk_step;   // one chain step (memory read data valid)
    logic walk_last;   // push root and add entry
    logic pop;         // pop one pixel
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;        // decode_done
    logic limit_hit;   // pixel_count >= pixel_limit
    logic stack_empty;
    logic bits_short;  // too few bits held for the code
    logic stream_end;
    logic code_clear;
    logic code_bad;    // end code, invalid, bad size: finish
    logic chain_more;  // current walk pointer still above root
  } dp_stat_t;

endpackage

>>> hdl/gld_stream_if.sv
// -----------------------------------------------------------------------------
// gld_stream_if: valid/ready channels for the decoder
// Input channel carries action/data_byte, output carries the result fields.
// -----------------------------------------------------------------------------
interface gld_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  modport source (output valid, action, data_byte, input ready);
  modport sink (input valid, action, data_byte, output ready);
endinterface

interface gld_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_index;
  logic [2:0]  status;
  logic [26:0] pixels_so_far;
  modport source (output valid, pixel_index, status, pixels_so_far, input ready);
  modport sink (input valid, pixel_index, status, pixels_so_far, output ready);
endinterface

>>> hdl/gld_datapath.sv
// -----------------------------------------------------------------------------
// gld_datapath: bit accumulator, dictionary memories, string stack, counters
// Executes one command per cycle from the controller.
// -----------------------------------------------------------------------------
module gld_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  gld_pkg::dp_cmd_t    cmd,
  input  logic [7:0]          byte_in,
  input  logic [3:0]          min_code_size,
  input  logic [26:0]         pixel_limit,
  output gld_pkg::dp_stat_t   stat,
  output logic [7:0]          pix_out,
  output logic [26:0]         pixel_count,
  output logic                byte_ok
);

  logic [11:0] prefix_mem [4096];
  logic [7:0]  suffix_mem [4096];
  logic [7:0]  first_mem  [4096];
  logic [7:0]  stack_mem  [4096];

  logic [19:0] acc_r;
  logic [4:0]  held_r;
  logic [3:0]  width_r;
  logic [12:0] nfree_r;
  logic [11:0] prev_r;
  logic        prev_ok_r;
  logic [12:0] depth_r;
  logic [26:0] count_r;
  logic [7:0]  sub_r;
  logic        ended_r;
  logic        done_r;

  // walk state
  logic [11:0] code_r;     // code being expanded
  logic        kwk_r;
  logic [11:0] t_r;        // chain pointer
  logic [12:0] guard_r;
  logic [7:0]  prev_first_r;  // first byte of previous code
  logic [11:0] rd_addr;
  logic [11:0] pre_q_r;
  logic [7:0]  suf_q_r, fst_q_r;
  logic [7:0]  pop_q_r;

  logic        size_ok;
  logic [12:0] clear_c;
  logic [3:0]  w_eff;
  logic [11:0] code_c;
  logic [11:0] mask_c;
  logic        kwk_c;
  logic [12:0] depth_dec;

  assign size_ok = (min_code_size >= 4'd1) && (min_code_size <= 4'd11);
  assign clear_c = 13'd1 << min_code_size;
  always_comb begin
    w_eff = width_r;
    if (width_r > 4'(gld_pkg::MAX_WIDTH)) w_eff = 4'(gld_pkg::MAX_WIDTH);
    if (width_r < 4'd1) w_eff = 4'd1;
  end
  assign mask_c = 12'((13'd1 << w_eff) - 13'd1);
  assign code_c = acc_r[11:0] & mask_c;
  assign kwk_c  = ({1'b0, code_c} == nfree_r);

  assign stat.done        = done_r;
  assign stat.limit_hit   = count_r >= pixel_limit;
  assign stat.stack_empty = depth_r == 13'd0;
  assign stat.bits_short  = held_r < {1'b0, w_eff};
  assign stat.stream_end  = ended_r;
  assign stat.code_clear  = {1'b0, code_c} == clear_c;
  assign stat.code_bad    = !size_ok || ({1'b0, code_c} == clear_c + 13'd1) ||
                            ({1'b0, code_c} > nfree_r) || (kwk_c && !prev_ok_r);
  assign stat.chain_more  = ({1'b0, t_r} >= clear_c) && (guard_r < 13'd4096);

  assign byte_ok = !done_r && !ended_r && (sub_r == 8'd0 || held_r <= 5'd12);
  assign pixel_count = count_r;
  assign pix_out = pop_q_r;
  assign depth_dec = depth_r - 13'd1;

  // chain read address: pointer for the next step
  assign rd_addr = cmd.walk_start ? (kwk_c ? prev_r : code_c) :
                   (cmd.walk_step ? pre_q_r : t_r);

  always_ff @(posedge clk) begin
    pre_q_r <= prefix_mem[rd_addr];
    suf_q_r <= suffix_mem[rd_addr];
    fst_q_r <= first_mem[prev_r];
    pop_q_r <= stack_mem[depth_dec[11:0]];
  end

  logic        push_en;
  logic [7:0]  push_val;
  logic        add_en;
  logic [11:0] add_addr;
  logic [7:0]  add_suf;

  always_ff @(posedge clk) begin
    if (push_en && depth_r < 13'd4096) stack_mem[depth_r[11:0]] <= push_val;
    if (add_en) begin
      prefix_mem[add_addr] <= prev_r;
      suffix_mem[add_addr] <= add_suf;
      first_mem[add_addr]  <= prev_first_r;
    end
  end

  logic [7:0] root_c;
  assign root_c   = t_r[7:0];
  assign add_addr = nfree_r[11:0];
  // suffix: first byte of previous (kwk) or of the code's own string (root)
  assign add_suf  = kwk_r ? prev_first_r : root_c;

  always_comb begin
    push_en  = 1'b0;
    push_val = suf_q_r;
    add_en   = 1'b0;
    if (cmd.walk_start && kwk_c) begin
      push_en = 1'b1; push_val = prev_first_r;
    end else if (cmd.walk_step) begin
      push_en = 1'b1; push_val = suf_q_r;
    end else if (cmd.walk_last) begin
      push_en = 1'b1; push_val = root_c;
      add_en  = prev_ok_r && (nfree_r < 13'd4096);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0; held_r <= '0; width_r <= '0; nfree_r <= '0;
      prev_r <= '0; prev_ok_r <= 1'b0; depth_r <= '0; count_r <= '0;
      sub_r <= '0; ended_r <= 1'b0; done_r <= 1'b1;
      code_r <= '0; kwk_r <= 1'b0; t_r <= '0; guard_r <= '0; prev_first_r <= '0;
    end else begin
      if (cmd.start) begin
        acc_r <= '0; held_r <= '0; prev_r <= '0; prev_ok_r <= 1'b0;
        depth_r <= '0; count_r <= '0; sub_r <= '0; ended_r <= 1'b0;
        if (size_ok) begin
          width_r <= min_code_size + 4'd1;
          nfree_r <= clear_c + 13'd2;
          done_r  <= 1'b0;
        end else begin
          width_r <= '0; nfree_r <= '0; done_r <= 1'b1;
        end
      end
      if (cmd.take_byte && byte_ok) begin
        if (sub_r == 8'd0) begin
          sub_r <= byte_in;
          if (byte_in == 8'd0) ended_r <= 1'b1;
        end else begin
          acc_r   <= acc_r | 20'({12'd0, byte_in} << held_r);
          held_r  <= held_r + 5'd8;
          sub_r   <= sub_r - 8'd1;
        end
      end
      if (cmd.end_data) ended_r <= 1'b1;
      // finish: controller raises read_code when bits short and ended,
      // or a bad code, or limit: signalled through read_code+status
      if (cmd.read_code) begin
        if (!size_ok || (stat.bits_short && ended_r) ||
            (!stat.bits_short && !stat.code_clear && stat.code_bad) ||
            (!done_r && count_r >= pixel_limit)) begin
          done_r <= 1'b1; depth_r <= '0;
        end else if (!stat.bits_short) begin
          acc_r  <= acc_r >> w_eff;
          held_r <= held_r - {1'b0, w_eff};
          if (stat.code_clear) begin
            nfree_r <= clear_c + 13'd2;
            width_r <= min_code_size + 4'd1;
            prev_ok_r <= 1'b0;
          end
        end
      end
      if (cmd.walk_start) begin
        code_r  <= code_c;
        kwk_r   <= kwk_c;
        t_r     <= kwk_c ? prev_r : code_c;
        guard_r <= '0;
        depth_r <= kwk_c ? 13'd1 : 13'd0;
        // first byte of prev from memory arrives in fst_q_r; resolve root case
        prev_first_r <= ({1'b0, prev_r} < clear_c) ? prev_r[7:0] : fst_q_r;
      end
      if (cmd.walk_step) begin
        t_r     <= pre_q_r;
        guard_r <= guard_r + 13'd1;
        if (depth_r < 13'd4096) depth_r <= depth_r + 13'd1;
      end
      if (cmd.walk_last) begin
        if (depth_r < 13'd4096) depth_r <= depth_r + 13'd1;
        if (prev_ok_r && nfree_r < 13'd4096) begin
          nfree_r <= nfree_r + 13'd1;
          if (width_r < 4'(gld_pkg::MAX_WIDTH) && nfree_r + 13'd1 == (13'd1 << width_r))
            width_r <= width_r + 4'd1;
        end
        prev_r    <= code_r;
        prev_ok_r <= 1'b1;
        // first byte of the new previous code for the next walk
        prev_first_r <= kwk_r ? prev_first_r : root_c;
      end
      if (cmd.pop) begin
        depth_r <= depth_dec;
        count_r <= count_r + 27'd1;
        if (count_r + 27'd1 >= pixel_limit) begin
          done_r <= 1'b1; depth_r <= '0;
        end
      end
    end
  end

endmodule

>>> hdl/gld_controller.sv
// -----------------------------------------------------------------------------
// gld_controller: transaction sequencing for the decoder
// Steps code reads, chain walks and pops; builds the result transaction.
// -----------------------------------------------------------------------------
module gld_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_action,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic              out_pix_sel,
  output gld_pkg::dp_cmd_t  cmd,
  input  gld_pkg::dp_stat_t stat,
  input  logic              byte_ok
);

  typedef enum logic [3:0] {
    S_IDLE, S_LIMIT, S_READ, S_WSTART, S_WSTEP, S_WWAIT, S_POP, S_POPWAIT, S_DONE, S_OUT
  } state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  status_r, status_nxt;
  logic        sel_r, sel_nxt;
  logic        acc;

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = (state_r == S_OUT);
  assign out_status  = status_r;
  assign out_pix_sel = sel_r;
  assign acc = in_valid && in_ready;

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    sel_nxt    = sel_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          sel_nxt = 1'b0;
          state_nxt = S_OUT;
          case (in_action)
            gld_pkg::ACT_START: begin
              cmd.start = 1'b1; status_nxt = gld_pkg::ST_NEED_BYTE;
              state_nxt = S_DONE;
            end
            gld_pkg::ACT_BYTE: begin
              cmd.take_byte = 1'b1;
              status_nxt = byte_ok ? gld_pkg::ST_TAKEN : gld_pkg::ST_REJECTED;
            end
            gld_pkg::ACT_END: begin
              cmd.end_data = 1'b1; status_nxt = gld_pkg::ST_TAKEN;
            end
            default: state_nxt = S_LIMIT;
          endcase
        end
      end
      S_LIMIT: begin
        if (stat.done) state_nxt = S_DONE;
        else if (stat.limit_hit) begin
          cmd.read_code = 1'b1; state_nxt = S_DONE;
        end else if (!stat.stack_empty) state_nxt = S_POP;
        else state_nxt = S_READ;
      end
      S_READ: begin
        if (stat.bits_short || stat.code_clear || stat.code_bad) begin
          cmd.read_code = 1'b1;
          if (stat.bits_short && !stat.stream_end) begin
            status_nxt = gld_pkg::ST_NEED_BYTE; state_nxt = S_OUT;
          end else if (stat.code_clear && !stat.bits_short) state_nxt = S_READ;
          else state_nxt = S_DONE;
        end else begin
          cmd.read_code = 1'b1;
          cmd.walk_start = 1'b1;
          state_nxt = S_WSTART;
        end
      end
      S_WSTART: state_nxt = S_WSTEP;
      S_WSTEP: begin
        if (stat.chain_more) begin
          cmd.walk_step = 1'b1; state_nxt = S_WWAIT;
        end else begin
          cmd.walk_last = 1'b1; state_nxt = S_POP;
        end
      end
      S_WWAIT: state_nxt = S_WSTEP;
      S_POP: state_nxt = S_POPWAIT;   // stack read address settles
      S_POPWAIT: begin
        cmd.pop = 1'b1; sel_nxt = 1'b1;
        status_nxt = gld_pkg::ST_PIXEL; state_nxt = S_OUT;
      end
      S_DONE: begin
        if (status_r != gld_pkg::ST_NEED_BYTE || stat.done)
          status_nxt = (cmd.start || status_r == gld_pkg::ST_NEED_BYTE) ?
                       gld_pkg::ST_DONE_NONE : gld_pkg::ST_DONE_OK;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; status_r <= '0; sel_r <= 1'b0;
    end else begin
      state_r <= state_nxt; status_r <= status_nxt; sel_r <= sel_nxt;
    end
  end

endmodule

>>> hdl/gld_finish.sv
// -----------------------------------------------------------------------------
// gld_finish: finished-status resolution
// Picks status 3 or 4 from the pixel count once decoding has ended.
// -----------------------------------------------------------------------------
module gld_finish (
  input  logic [2:0]  status_in,
  input  logic        done,
  input  logic [26:0] count,
  output logic [2:0]  status_out
);
  always_comb begin
    status_out = status_in;
    if (done && (status_in == gld_pkg::ST_DONE_OK || status_in == gld_pkg::ST_DONE_NONE ||
                 status_in == gld_pkg::ST_NEED_BYTE))
      status_out = (count != 27'd0) ? gld_pkg::ST_DONE_OK : gld_pkg::ST_DONE_NONE;
  end
endmodule

>>> hdl/gld_lzw_top_wrap.sv
// -----------------------------------------------------------------------------
// gld_cfg_regs: configuration register file
// Holds min_code_size and pixel_limit, written through the cfg port.
// -----------------------------------------------------------------------------
module gld_cfg_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [26:0] cfg_wdata,
  output logic [3:0]  min_code_size,
  output logic [26:0] pixel_limit
);
  logic [3:0]  mcs_r;
  logic [26:0] lim_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcs_r <= 4'd8; lim_r <= 27'd65536;
    end else if (cfg_we) begin
      if (cfg_index == gld_pkg::REG_MIN_CODE_SIZE) mcs_r <= cfg_wdata[3:0];
      if (cfg_index == gld_pkg::REG_PIXEL_LIMIT)   lim_r <= cfg_wdata;
    end
  end
  assign min_code_size = mcs_r;
  assign pixel_limit   = lim_r;
endmodule

>>> hdl/gif_lzw_decoder_top.sv
// -----------------------------------------------------------------------------
// gif_lzw_decoder_top: GIF LZW image data decoder, pull interface
// Controller plus datapath; one result transaction per input transaction.
// -----------------------------------------------------------------------------
//  channel | direction | fields
//  in      | sink      | action[1:0], data_byte[7:0]
//  out     | source    | pixel_index[7:0], status[2:0], pixels_so_far[26:0]
//  cfg     | write     | cfg_we, cfg_index[3:0], cfg_wdata[26:0]
//
// One transaction at a time: byte and end go from idle to output, start
// via done, a pull with stacked pixels via limit, pop and pop-wait; a code
// read adds a walk step per prefix-chain character (one dictionary read
// each). Synchronous active-low reset leaves the decoder finished. A
// stalled out channel holds the result and blocks the next input.
module gif_lzw_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  gld_in_if.sink      in_ch,
  gld_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [26:0] cfg_wdata
);

  gld_pkg::dp_cmd_t  cmd;
  gld_pkg::dp_stat_t stat;
  logic [3:0]  mcs;
  logic [26:0] lim;
  logic [7:0]  pix;
  logic [26:0] cnt;
  logic        byte_ok;
  logic [2:0]  st_raw;
  logic        sel;
  logic [7:0]  pix_r;
  logic [7:0]  byte_r;

  // register the accepted input byte (unused; the datapath takes it directly) and the popped pixel
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) byte_r <= in_ch.data_byte;
    if (cmd.pop) pix_r <= pix;
  end

  gld_cfg_regs u_cfg (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .min_code_size(mcs), .pixel_limit(lim)
  );

  gld_controller u_ctl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_action(in_ch.action),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_status(st_raw), .out_pix_sel(sel), .cmd, .stat, .byte_ok
  );

  gld_datapath u_dp (
    .clk, .rst_n, .cmd, .byte_in(in_ch.data_byte), .min_code_size(mcs),
    .pixel_limit(lim), .stat, .pix_out(pix), .pixel_count(cnt), .byte_ok
  );

  gld_finish u_fin (
    .status_in(st_raw), .done(stat.done && !sel), .count(cnt),
    .status_out(out_ch.status)
  );

  assign out_ch.pixel_index   = sel ? pix_r : 8'd0;
  assign out_ch.pixels_so_far = cnt;

  logic unused_byte;
  assign unused_byte = ^byte_r;

endmodule

>>> dv/gld_checker.sv
// -----------------------------------------------------------------------------
// gld_checker: result predictor and scoreboard for the GIF LZW decoder
// Watches the in, out and cfg ports, predicts one result per input
// transaction and compares every result transaction field by field.
// -----------------------------------------------------------------------------
module gld_checker
  import gld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  gld_in_if           in_ch,
  gld_out_if          out_ch,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [26:0] cfg_wdata,
  output int          errors,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]         pix;
    status_t            st;
    logic [COUNT_W-1:0] cnt;
  } lzw_result_t;

  lzw_result_t result_q[$];

  // decoder image
  logic [11:0] prefix_mem[4096];
  logic [7:0]  suffix_mem[4096];
  logic [7:0]  head_mem[4096];
  logic [7:0]  char_stack[4096];
  int unsigned acc_bits, bits_in, code_w, free_code, last_code, depth;
  int unsigned pix_cnt, block_left, min_size, pix_limit;
  bit          last_ok, eos, finished;

  function automatic void stop_decode();
    finished = 1'b1;
    depth    = 0;
  endfunction

  function automatic void push_char(int unsigned v);
    if (depth < 4096) begin
      char_stack[depth] = v[7:0];
      depth++;
    end
  endfunction

  function automatic int unsigned head_of(int unsigned t, int unsigned clr);
    if (t < clr) return t & 8'hFF;
    return head_mem[t & 12'hFFF];
  endfunction

  // reads codes until one expands to a string, bits run short, or decode stops
  function automatic void expand_next_code();
    int unsigned clr, endc, w, code, t, guard;
    bit kwk;
    while (1) begin
      if (min_size < 1 || min_size > 11) begin
        stop_decode();
        return;
      end
      clr  = 1 << min_size;
      endc = clr + 1;
      w    = code_w;
      if (w > 12) w = 12;
      if (w < 1) w = 1;
      if (bits_in < w) begin
        if (eos) stop_decode();
        return;
      end
      code     = acc_bits & ((1 << w) - 1);
      acc_bits = acc_bits >> w;
      bits_in  = bits_in - w;
      if (code == clr) begin
        free_code = endc + 1;
        code_w    = min_size + 1;
        last_ok   = 1'b0;
        continue;
      end
      if (code == endc || code > free_code) begin
        stop_decode();
        return;
      end
      kwk = (code == free_code);
      if (kwk && !last_ok) begin
        stop_decode();
        return;
      end
      t     = code;
      guard = 0;
      depth = 0;
      if (kwk) begin
        push_char(head_of(last_code, clr));
        t = last_code;
      end
      while (t >= clr && guard < 4096) begin
        push_char(suffix_mem[t & 12'hFFF]);
        t = prefix_mem[t & 12'hFFF];
        guard++;
      end
      push_char(t);
      if (last_ok && free_code < 4096) begin
        prefix_mem[free_code] = last_code[11:0];
        suffix_mem[free_code] = kwk ? head_of(last_code, clr) : head_of(code, clr);
        head_mem[free_code]   = head_of(last_code, clr);
        free_code++;
        if (code_w < MAX_WIDTH && free_code == (1 << code_w)) code_w++;
      end
      last_code = code & 12'hFFF;
      last_ok   = 1'b1;
      return;
    end
  endfunction

  function automatic lzw_result_t decode_transaction(action_t act, logic [7:0] data);
    lzw_result_t r;
    r.pix = 8'd0;
    case (act)
      ACT_START: begin
        acc_bits = 0; bits_in = 0; last_code = 0; last_ok = 0; depth = 0;
        pix_cnt = 0; block_left = 0; eos = 0;
        if (min_size < 1 || min_size > 11) begin
          code_w = 0; free_code = 0; finished = 1'b1;
          r.st = ST_DONE_NONE;
        end else begin
          code_w = min_size + 1; free_code = (1 << min_size) + 2; finished = 1'b0;
          r.st = ST_NEED_BYTE;
        end
      end
      ACT_BYTE: begin
        if (finished || eos) begin
          r.st = ST_REJECTED;
        end else if (block_left == 0) begin
          block_left = data;
          if (data == 0) eos = 1'b1;
          r.st = ST_TAKEN;
        end else if (bits_in > 12) begin
          r.st = ST_REJECTED;
        end else begin
          acc_bits = (acc_bits | (int'(data) << bits_in)) & 20'hFFFFF;
          bits_in += 8;
          block_left--;
          r.st = ST_TAKEN;
        end
      end
      ACT_END: begin
        eos  = 1'b1;
        r.st = ST_TAKEN;
      end
      default: begin
        if (!finished && pix_cnt >= pix_limit) stop_decode();
        if (!finished && depth == 0) expand_next_code();
        if (finished) begin
          r.st = (pix_cnt > 0) ? ST_DONE_OK : ST_DONE_NONE;
        end else if (depth > 0) begin
          depth--;
          r.pix   = char_stack[depth];
          pix_cnt = (pix_cnt + 1) & 27'h7FFFFFF;
          if (pix_cnt >= pix_limit) stop_decode();
          r.st = ST_PIXEL;
        end else begin
          r.st = ST_NEED_BYTE;
        end
      end
    endcase
    r.cnt = pix_cnt[COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    lzw_result_t want;
    if (!rst_n) begin
      min_size = 8; pix_limit = 65536;
      acc_bits = 0; bits_in = 0; code_w = 0; free_code = 0; last_code = 0;
      last_ok = 0; depth = 0; pix_cnt = 0; block_left = 0; eos = 0; finished = 1;
      result_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MIN_CODE_SIZE) min_size = cfg_wdata[3:0];
        else if (cfg_index == REG_PIXEL_LIMIT) pix_limit = cfg_wdata;
      end
      if (in_ch.valid && in_ch.ready)
        result_q.push_back(decode_transaction(action_t'(in_ch.action), in_ch.data_byte));
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result transaction status=%0d", $realtime,
                   out_ch.status);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (out_ch.status !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $realtime, want.st,
                     out_ch.status);
            errors++;
          end
          if (out_ch.pixel_index !== want.pix) begin
            $display("%0t: pixel_index expected %0d actual %0d", $realtime, want.pix,
                     out_ch.pixel_index);
            errors++;
          end
          if (out_ch.pixels_so_far !== want.cnt) begin
            $display("%0t: pixels_so_far expected %0d actual %0d", $realtime, want.cnt,
                     out_ch.pixels_so_far);
            errors++;
          end
        end
      end
    end
    outstanding = result_q.size();
  end

  initial begin
    errors      = 0;
    outstanding = 0;
  end

endmodule

>>> dv/tb_gif_lzw_decoder_top.sv
// -----------------------------------------------------------------------------
// tb_gif_lzw_decoder_top: testbench top for the GIF LZW decoder
// Encodes random LZW code streams into framed GIF data, feeds them with
// pulls in reaction to the decoder's status, and leaves checking to
// gld_checker. Also covers bad sizes, broken streams and output stalls.
// -----------------------------------------------------------------------------
module tb_gif_lzw_decoder_top;
  import gld_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1950;
  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [3:0]  cfg_index;
  logic [26:0] cfg_wdata;
  int          errors;
  int          outstanding;

  gld_in_if  in_ch ();
  gld_out_if out_ch ();

  gif_lzw_decoder_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  gld_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // run-away guard
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_gif_lzw_decoder_top NOT OK");
      $finish;
    end
  end

  bit      quiet    = 1'b0;  // no idling on either side
  bit      hold_req = 1'b0;  // ask the receiver for one long stall
  int      sent     = 0;     // accepted input transactions
  status_t last_st  = ST_DONE_NONE;
  int      cur_min  = 8;

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // One input transaction. With wait_res set, valid drops after acceptance and
  // the status of this transaction's result is captured in last_st.
  task automatic put_item(action_t act, logic [7:0] data, bit wait_res);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.action    = act;
    in_ch.data_byte = data;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sent++;
    if (wait_res) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      last_st = status_t'(out_ch.status);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // register writes only with the decoder drained
  task automatic write_reg(logic [3:0] idx, int unsigned val);
    drain();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val[26:0];
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_MIN_CODE_SIZE) cur_min = val;
  endtask

  int          code_q[$];
  logic [7:0]  stream_q[$];

  // Random code sequence: clears, roots, known entries and the KwKwK code, then the end code,
  // a random code or nothing, tracking the dictionary exactly as the decoder grows it.
  task automatic make_codes(int mn, int n, bit lead_clear, bit good_end);
    int clr, endc, nf, c, r;
    bit pv;
    clr  = 1 << mn;
    endc = clr + 1;
    nf   = clr + 2;
    pv   = 1'b0;
    code_q.delete();
    if (lead_clear) code_q.push_back(clr);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        c  = clr;
        nf = endc + 1;
        pv = 1'b0;
      end else begin
        if (!pv || r < 55) c = $urandom_range(0, clr - 1);
        else c = $urandom_range(endc + 1, (nf > 4095) ? 4095 : nf);
        if (pv && nf < 4096) nf++;
        pv = 1'b1;
      end
      code_q.push_back(c);
    end
    if (good_end) code_q.push_back(endc);
    else if ($urandom_range(0, 1)) code_q.push_back($urandom_range(0, 4095));
  endtask

  // Packs code_q LSB-first at the decoder's running width, then frames it
  // into sub-blocks with a zero-length terminator (sometimes left off).
  task automatic pack_stream(int mn, bit terminate);
    int clr, endc, nf, w, nbits, len;
    bit pv;
    longint unsigned acc;
    logic [7:0] raw[$];
    clr   = 1 << mn;
    endc  = clr + 1;
    nf    = clr + 2;
    w     = mn + 1;
    pv    = 1'b0;
    acc   = 0;
    nbits = 0;
    foreach (code_q[i]) begin
      acc   = acc | (longint'(code_q[i] & ((1 << w) - 1)) << nbits);
      nbits = nbits + w;
      while (nbits >= 8) begin
        raw.push_back(acc[7:0]);
        acc   = acc >> 8;
        nbits = nbits - 8;
      end
      if (code_q[i] == clr) begin
        nf = endc + 1;
        w  = mn + 1;
        pv = 1'b0;
      end else begin
        if (pv && nf < 4096) begin
          nf++;
          if (w < 12 && nf == (1 << w)) w++;
        end
        pv = 1'b1;
      end
    end
    if (nbits > 0) raw.push_back(acc[7:0]);
    stream_q.delete();
    while (raw.size() > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8);
      if (len > raw.size()) len = raw.size();
      stream_q.push_back(len[7:0]);
      repeat (len) stream_q.push_back(raw.pop_front());
    end
    if (terminate) stream_q.push_back(8'd0);
  endtask

  // Start an image and keep it going: bytes when the decoder asks or at
  // random (an end and a pull once the stream runs out), pulls otherwise, until it reports finished.
  task automatic feed_image();
    int idx;
    bit want;
    idx = 0;
    put_item(ACT_START, $urandom_range(0, 255), 1'b1);
    while (last_st != ST_DONE_OK && last_st != ST_DONE_NONE) begin
      want = (last_st == ST_NEED_BYTE) || ($urandom_range(0, 3) == 0);
      if (want && idx < stream_q.size()) begin
        put_item(ACT_BYTE, stream_q[idx], 1'b1);
        if (last_st == ST_TAKEN) idx++;
      end else if (want) begin
        put_item(ACT_END, $urandom_range(0, 255), 1'b1);
        put_item(ACT_PULL, $urandom_range(0, 255), 1'b1);
      end else begin
        put_item(ACT_PULL, $urandom_range(0, 255), 1'b1);
      end
    end
  endtask

  // start plus random actions, weighted toward bytes and pulls
  task automatic noise_burst(int n);
    int r;
    put_item(ACT_START, $urandom_range(0, 255), 1'b1);
    repeat (n) begin
      r = $urandom_range(0, 19);
      put_item((r == 0) ? ACT_START : (r == 1) ? ACT_END : (r < 11) ? ACT_BYTE : ACT_PULL,
               $urandom_range(0, 255), 1'b1);
    end
  endtask

  int mn;
  int r;

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_MIN_CODE_SIZE;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_START;
    in_ch.data_byte = 8'd0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // --- directed ---
    // before any start the decoder sits finished: end, byte, pull
    put_item(ACT_END, 8'hFF, 1'b1);
    put_item(ACT_BYTE, 8'h00, 1'b1);
    put_item(ACT_PULL, 8'h00, 1'b1);
    // illegal size zero: start reports no pixels
    write_reg(REG_MIN_CODE_SIZE, 0);
    put_item(ACT_START, 8'h00, 1'b1);
    put_item(ACT_PULL, 8'h00, 1'b1);
    // size 2 by hand: clear, root, KwKwK, root, end code; pixel limit 67108864
    write_reg(REG_MIN_CODE_SIZE, 2);
    write_reg(REG_PIXEL_LIMIT, 67108864);
    code_q = '{4, 1, 6, 2, 5};
    pack_stream(2, 1'b1);
    feed_image();
    // code beyond the dictionary ends the decode
    code_q = '{4, 0, 7};
    pack_stream(2, 1'b1);
    feed_image();
    // accumulator full rejects a third byte; size made illegal mid-image
    write_reg(REG_MIN_CODE_SIZE, 11);
    put_item(ACT_START, 8'h00, 1'b1);
    put_item(ACT_BYTE, 8'd5, 1'b1);
    put_item(ACT_BYTE, 8'hFF, 1'b1);
    put_item(ACT_BYTE, 8'hFF, 1'b1);
    put_item(ACT_BYTE, 8'hA5, 1'b1);
    write_reg(REG_MIN_CODE_SIZE, 15);
    put_item(ACT_PULL, 8'h00, 1'b1);
    // size 1 with a one-pixel limit
    write_reg(REG_MIN_CODE_SIZE, 1);
    write_reg(REG_PIXEL_LIMIT, 1);
    make_codes(1, 6, 1'b1, 1'b1);
    pack_stream(1, 1'b1);
    feed_image();

    // --- random ---
    while (sent < ITEM_TARGET) begin
      if (sent > ITEM_TARGET - 250) quiet = 1'b1;
      r = $urandom_range(0, 19);
      mn = (r == 0) ? 0 : (r == 1) ? 12 : (r == 2) ? 1 : (r == 3) ? 11 : $urandom_range(1, 11);
      if (mn != cur_min) write_reg(REG_MIN_CODE_SIZE, mn);
      r = $urandom_range(0, 19);
      write_reg(REG_PIXEL_LIMIT, (r < 2) ? $urandom_range(1, 3) :
                (r < 4) ? 67108864 : $urandom_range(4, 400));

      // one long receiver stall with the sender still offering
      if (sent > ITEM_TARGET / 2 && hold_req == 1'b0 && !quiet && cycles > 0
          && r == 5) begin
        hold_req = 1'b1;
        put_item(ACT_START, 8'h00, 1'b0);
        repeat (6) put_item(ACT_PULL, $urandom_range(0, 255), 1'b0);
        while (hold_req) @(negedge clk);
        drain();
      end

      if ($urandom_range(0, 6) == 0) begin
        noise_burst($urandom_range(10, 30));
      end else if (mn >= 1 && mn <= 11) begin
        make_codes(mn, ($urandom_range(0, 15) == 0) ? $urandom_range(100, 200)
                                                    : $urandom_range(3, 40),
                   $urandom_range(0, 4) != 0, $urandom_range(0, 5) != 0);
        pack_stream(mn, $urandom_range(0, 4) != 0);
        feed_image();
      end else begin
        put_item(ACT_START, $urandom_range(0, 255), 1'b1);
        put_item(ACT_PULL, $urandom_range(0, 255), 1'b1);
      end
    end

    // wind down: everything answered, then a settle period
    drain();
    if (errors == 0) begin
      $display("tb_gif_lzw_decoder_top OK");
    end else begin
      $display("tb_gif_lzw_decoder_top NOT OK");
    end
    $finish;
  end

endmodule
